@@ hw/rtl/uvd_pkg.sv @@
// Package for the unique value deque: command and status codes, datapath
// select codes and the control and status structs shared by its modules.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package uvd_pkg;

    localparam int DEFAULT_CAPACITY = 16;

    localparam int CMD_W = 3;
    localparam int VAL_W = 32;
    localparam int ST_W  = 3;
    localparam int CNT_W = 5;

    localparam logic [CMD_W-1:0] CMD_PUSH_TOP    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BOTTOM = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE      = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_TOP     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR       = 3'd4;

    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_DUP      = 3'd1;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd2;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd3;
    localparam logic [ST_W-1:0] ST_EMPTY    = 3'd4;

    // Memory read address selects.
    localparam logic [1:0] RA_PTR       = 2'd0;
    localparam logic [1:0] RA_PTR_NEXT  = 2'd1;
    localparam logic [1:0] RA_HEAD      = 2'd2;
    localparam logic [1:0] RA_TAIL_PREV = 2'd3;

    // Memory write address selects.
    localparam logic [1:0] WA_PTR       = 2'd0;
    localparam logic [1:0] WA_HEAD_PREV = 2'd1;
    localparam logic [1:0] WA_TAIL      = 2'd2;

    typedef struct packed {
        logic            latch_in;
        logic            mem_rd;
        logic [1:0]      rd_sel;
        logic            mem_wr;
        logic [1:0]      wr_sel;
        logic            wr_from_mem;
        logic            ptr_load_head;
        logic            ptr_inc;
        logic            idx_clr;
        logic            idx_inc;
        logic            head_inc;
        logic            head_dec;
        logic            tail_inc;
        logic            tail_dec;
        logic            occ_inc;
        logic            occ_dec;
        logic            clear;
        logic            set_status;
        logic [ST_W-1:0] status_code;
        logic            top_cap;
        logic            bot_cap;
        logic            res_zero;
        logic            out_load;
    } uvd_ctrl_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             occ_zero;
        logic             occ_full;
        logic             idx_last;
        logic             match;
    } uvd_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/unique_value_deque_top.sv @@
// Top level of the unique value deque: joins the controller and the datapath.
// Depends on uvd_pkg, uvd_controller and uvd_datapath.
//
//   channel  handshake            payload
//   input    in_valid / in_stall  command, value
//   output   out_valid/out_stall  status, top_value, bottom_value, entry_count, is_empty
//
// A push compares the new value with each held value in turn, then writes it unless the
// store is full; a duplicate or a failed remove ends after its compares. A remove that
// finds its value moves every value below it up one place, reading and writing each; pop,
// clear, spare commands and non-push commands on an empty store need no scan.
// The steps are set by the value memory's one registered access a cycle. The next word
// is taken in the cycle after the result loads; a result held by out_stall blocks the load.
// Reset empties the store at once; the memory itself is not cleared.
// A new word is taken while an earlier result still waits on out_stall.
`timescale 1ns / 1ps
`default_nettype none

module unique_value_deque_top
    import uvd_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [CMD_W-1:0]         command,
    input  wire logic signed [VAL_W-1:0]  value,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic [ST_W-1:0]               status,
    output logic signed [VAL_W-1:0]       top_value,
    output logic signed [VAL_W-1:0]       bottom_value,
    output logic [CNT_W-1:0]              entry_count,
    output logic                          is_empty
);

    uvd_ctrl_t ctrl;
    uvd_stat_t stat;

    uvd_controller u_controller (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    uvd_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .stat         (stat),
        .command      (command),
        .value        (value),
        .status       (status),
        .top_value    (top_value),
        .bottom_value (bottom_value),
        .entry_count  (entry_count),
        .is_empty     (is_empty)
    );

endmodule

`default_nettype wire

@@ hw/rtl/uvd_datapath.sv @@
// Datapath of the unique value deque: circular value memory, head and tail
// pointers, scan pointer and counters, and the result and output registers.
// Depends on uvd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module uvd_datapath
    import uvd_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire uvd_ctrl_t                ctrl,
    output uvd_stat_t                     stat,
    input  wire logic [CMD_W-1:0]         command,
    input  wire logic signed [VAL_W-1:0]  value,
    output logic [ST_W-1:0]               status,
    output logic signed [VAL_W-1:0]       top_value,
    output logic signed [VAL_W-1:0]       bottom_value,
    output logic [CNT_W-1:0]              entry_count,
    output logic                          is_empty
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(CAPACITY - 1);
    localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

    function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
        ptr_next = (p == LAST_ADDR) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [AW-1:0] ptr_prev(input logic [AW-1:0] p);
        ptr_prev = (p == '0) ? LAST_ADDR : p - AW'(1);
    endfunction

    logic [VAL_W-1:0] mem [CAPACITY];
    logic [VAL_W-1:0] rdata_reg;

    logic [CMD_W-1:0] cmd_reg;
    logic [VAL_W-1:0] val_reg;
    logic [AW-1:0]    head_reg;
    logic [AW-1:0]    tail_reg;
    logic [AW-1:0]    ptr_reg;
    logic [CW-1:0]    idx_reg;
    logic [CW-1:0]    occ_reg;
    logic [ST_W-1:0]  st_reg;
    logic [VAL_W-1:0] res_top_reg;
    logic [VAL_W-1:0] res_bot_reg;

    logic [ST_W-1:0]  out_status_reg;
    logic [VAL_W-1:0] out_top_reg;
    logic [VAL_W-1:0] out_bot_reg;
    logic [CNT_W-1:0] out_count_reg;
    logic             out_empty_reg;

    logic [AW-1:0]    raddr;
    logic [AW-1:0]    waddr;
    logic [VAL_W-1:0] wdata;

    always_comb
    begin
        case (ctrl.rd_sel)
            RA_PTR:       raddr = ptr_reg;
            RA_PTR_NEXT:  raddr = ptr_next(ptr_reg);
            RA_HEAD:      raddr = head_reg;
            RA_TAIL_PREV: raddr = ptr_prev(tail_reg);
            default:      raddr = ptr_reg;
        endcase
        case (ctrl.wr_sel)
            WA_PTR:       waddr = ptr_reg;
            WA_HEAD_PREV: waddr = ptr_prev(head_reg);
            WA_TAIL:      waddr = tail_reg;
            default:      waddr = ptr_reg;
        endcase
        wdata = ctrl.wr_from_mem ? rdata_reg : val_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mem_wr)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mem_rd)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    // Control registers of the store.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            occ_reg  <= '0;
        end
        else if (ctrl.clear)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            occ_reg  <= '0;
        end
        else
        begin
            if (ctrl.head_inc)
            begin
                head_reg <= ptr_next(head_reg);
            end
            else if (ctrl.head_dec)
            begin
                head_reg <= ptr_prev(head_reg);
            end
            if (ctrl.tail_inc)
            begin
                tail_reg <= ptr_next(tail_reg);
            end
            else if (ctrl.tail_dec)
            begin
                tail_reg <= ptr_prev(tail_reg);
            end
            if (ctrl.occ_inc)
            begin
                occ_reg <= occ_reg + CW'(1);
            end
            else if (ctrl.occ_dec)
            begin
                occ_reg <= occ_reg - CW'(1);
            end
        end
    end

    // Working registers of the current word; no reset needed.
    always_ff @(posedge clk)
    begin
        if (ctrl.latch_in)
        begin
            cmd_reg <= command;
            val_reg <= value;
            st_reg  <= ST_OK;
        end
        else if (ctrl.set_status)
        begin
            st_reg <= ctrl.status_code;
        end
        if (ctrl.ptr_load_head)
        begin
            ptr_reg <= head_reg;
        end
        else if (ctrl.ptr_inc)
        begin
            ptr_reg <= ptr_next(ptr_reg);
        end
        if (ctrl.idx_clr)
        begin
            idx_reg <= '0;
        end
        else if (ctrl.idx_inc)
        begin
            idx_reg <= idx_reg + CW'(1);
        end
        if (ctrl.res_zero)
        begin
            res_top_reg <= '0;
            res_bot_reg <= '0;
        end
        else
        begin
            if (ctrl.top_cap)
            begin
                res_top_reg <= rdata_reg;
            end
            if (ctrl.bot_cap)
            begin
                res_bot_reg <= rdata_reg;
            end
        end
        if (ctrl.out_load)
        begin
            out_status_reg <= st_reg;
            out_top_reg    <= res_top_reg;
            out_bot_reg    <= res_bot_reg;
            out_count_reg  <= CNT_W'(occ_reg);
            out_empty_reg  <= (occ_reg == '0);
        end
    end

    assign stat.cmd      = cmd_reg;
    assign stat.occ_zero = (occ_reg == '0);
    assign stat.occ_full = (occ_reg == CAP_COUNT);
    assign stat.idx_last = (CW'(idx_reg + CW'(1)) == occ_reg);
    assign stat.match    = (rdata_reg == val_reg);

    assign status       = out_status_reg;
    assign top_value    = out_top_reg;
    assign bottom_value = out_bot_reg;
    assign entry_count  = out_count_reg;
    assign is_empty     = out_empty_reg;

`ifndef SYNTHESIS
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CAP_COUNT)
        else $error("occupancy above capacity");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.occ_inc |-> (occ_reg != CAP_COUNT) && ctrl.mem_wr)
        else $error("push into a full store or without a write");

    a_no_take_empty: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.occ_dec |-> (occ_reg != '0) && (ctrl.head_inc || ctrl.tail_dec))
        else $error("removal from an empty store or without a pointer move");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/uvd_controller.sv @@
// Controller state machine of the unique value deque: sequences the scan,
// push, shift and result read steps and runs both handshakes.
// Depends on uvd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module uvd_controller
    import uvd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  wire logic       out_stall,
    input  wire uvd_stat_t  stat,
    output uvd_ctrl_t       ctrl
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_START    = 4'd1;
    localparam logic [3:0] S_SCAN_RD  = 4'd2;
    localparam logic [3:0] S_SCAN_CMP = 4'd3;
    localparam logic [3:0] S_PUSH     = 4'd4;
    localparam logic [3:0] S_SHIFT_RD = 4'd5;
    localparam logic [3:0] S_SHIFT_WR = 4'd6;
    localparam logic [3:0] S_FINISH   = 4'd7;
    localparam logic [3:0] S_RD_TOP   = 4'd8;
    localparam logic [3:0] S_RD_BOT   = 4'd9;
    localparam logic [3:0] S_OUT      = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        ctrl       = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctrl.latch_in = 1'b1;
                    state_next    = S_START;
                end
            end
            S_START:
            begin
                ctrl.ptr_load_head = 1'b1;
                ctrl.idx_clr       = 1'b1;
                case (stat.cmd)
                    CMD_PUSH_TOP, CMD_PUSH_BOTTOM:
                    begin
                        state_next = stat.occ_zero ? S_PUSH : S_SCAN_RD;
                    end
                    CMD_REMOVE:
                    begin
                        if (stat.occ_zero)
                        begin
                            ctrl.set_status  = 1'b1;
                            ctrl.status_code = ST_NOTFOUND;
                            state_next       = S_FINISH;
                        end
                        else
                        begin
                            state_next = S_SCAN_RD;
                        end
                    end
                    CMD_POP_TOP:
                    begin
                        if (stat.occ_zero)
                        begin
                            ctrl.set_status  = 1'b1;
                            ctrl.status_code = ST_EMPTY;
                        end
                        else
                        begin
                            ctrl.head_inc = 1'b1;
                            ctrl.occ_dec  = 1'b1;
                        end
                        state_next = S_FINISH;
                    end
                    CMD_CLEAR:
                    begin
                        ctrl.clear = 1'b1;
                        state_next = S_FINISH;
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_SCAN_RD:
            begin
                ctrl.mem_rd = 1'b1;
                ctrl.rd_sel = RA_PTR;
                state_next  = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                if (stat.match)
                begin
                    if (stat.cmd == CMD_REMOVE)
                    begin
                        state_next = S_SHIFT_RD;
                    end
                    else
                    begin
                        ctrl.set_status  = 1'b1;
                        ctrl.status_code = ST_DUP;
                        state_next       = S_FINISH;
                    end
                end
                else if (stat.idx_last)
                begin
                    if (stat.cmd == CMD_REMOVE)
                    begin
                        ctrl.set_status  = 1'b1;
                        ctrl.status_code = ST_NOTFOUND;
                        state_next       = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_PUSH;
                    end
                end
                else
                begin
                    ctrl.ptr_inc = 1'b1;
                    ctrl.idx_inc = 1'b1;
                    state_next   = S_SCAN_RD;
                end
            end
            S_PUSH:
            begin
                if (stat.occ_full)
                begin
                    ctrl.set_status  = 1'b1;
                    ctrl.status_code = ST_FULL;
                end
                else if (stat.cmd == CMD_PUSH_TOP)
                begin
                    ctrl.mem_wr   = 1'b1;
                    ctrl.wr_sel   = WA_HEAD_PREV;
                    ctrl.head_dec = 1'b1;
                    ctrl.occ_inc  = 1'b1;
                end
                else
                begin
                    ctrl.mem_wr   = 1'b1;
                    ctrl.wr_sel   = WA_TAIL;
                    ctrl.tail_inc = 1'b1;
                    ctrl.occ_inc  = 1'b1;
                end
                state_next = S_FINISH;
            end
            S_SHIFT_RD:
            begin
                // The gap has reached the bottom once the scan index is the last one.
                if (stat.idx_last)
                begin
                    ctrl.tail_dec = 1'b1;
                    ctrl.occ_dec  = 1'b1;
                    state_next    = S_FINISH;
                end
                else
                begin
                    ctrl.mem_rd = 1'b1;
                    ctrl.rd_sel = RA_PTR_NEXT;
                    state_next  = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR:
            begin
                ctrl.mem_wr      = 1'b1;
                ctrl.wr_sel      = WA_PTR;
                ctrl.wr_from_mem = 1'b1;
                ctrl.ptr_inc     = 1'b1;
                ctrl.idx_inc     = 1'b1;
                state_next       = S_SHIFT_RD;
            end
            S_FINISH:
            begin
                if (stat.occ_zero)
                begin
                    ctrl.res_zero = 1'b1;
                    state_next    = S_OUT;
                end
                else
                begin
                    ctrl.mem_rd = 1'b1;
                    ctrl.rd_sel = RA_HEAD;
                    state_next  = S_RD_TOP;
                end
            end
            S_RD_TOP:
            begin
                ctrl.top_cap = 1'b1;
                ctrl.mem_rd  = 1'b1;
                ctrl.rd_sel  = RA_TAIL_PREV;
                state_next   = S_RD_BOT;
            end
            S_RD_BOT:
            begin
                ctrl.bot_cap = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    ctrl.out_load = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctrl.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

@@ tb/unique_value_deque_top_test.sv @@
// Self-checking testbench for unique_value_deque_top: directed edge cases, then random
// command streams checked word by word against an in-bench model of the deque.
// Depends on uvd_pkg and the RTL of unique_value_deque_top.
`timescale 1ns / 1ps

module unique_value_deque_top_test;
    import uvd_pkg::*;

    localparam int DEPTH         = DEFAULT_CAPACITY;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 100;

    // Command codes with no defined operation.
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [ST_W-1:0]         status;
        logic signed [VAL_W-1:0] top;
        logic signed [VAL_W-1:0] bottom;
        logic [CNT_W-1:0]        count;
        logic                    empty;
    } deque_view_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [CMD_W-1:0]        command = CMD_CLEAR;
    logic signed [VAL_W-1:0] value = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [ST_W-1:0]         status;
    logic signed [VAL_W-1:0] top_value;
    logic signed [VAL_W-1:0] bottom_value;
    logic [CNT_W-1:0]        entry_count;
    logic                    is_empty;

    // Values held by the deque as seen by the model, top first.
    logic signed [VAL_W-1:0] held_values[$];
    deque_view_t             expected_views[$];

    int error_count = 0;
    int cycle_count = 0;
    int stall_left  = 0;
    bit idle_on     = 1'b0;

    unique_value_deque_top #(
        .CAPACITY(DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .command(command),
        .value(value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .top_value(top_value),
        .bottom_value(bottom_value),
        .entry_count(entry_count),
        .is_empty(is_empty)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Applies one command to the model and returns the result the block must give.
    function automatic deque_view_t apply_command(input logic [CMD_W-1:0] cmd,
                                                  input logic signed [VAL_W-1:0] val);
        deque_view_t view;
        int          pos;
        pos = -1;
        foreach (held_values[i])
        begin
            if (pos < 0 && held_values[i] == val)
            begin
                pos = i;
            end
        end
        view.status = ST_OK;
        case (cmd)
            CMD_PUSH_TOP, CMD_PUSH_BOTTOM:
            begin
                if (pos >= 0)
                begin
                    view.status = ST_DUP;
                end
                else if (held_values.size() >= DEPTH)
                begin
                    view.status = ST_FULL;
                end
                else if (cmd == CMD_PUSH_TOP)
                begin
                    held_values.push_front(val);
                end
                else
                begin
                    held_values.push_back(val);
                end
            end
            CMD_REMOVE:
            begin
                if (pos >= 0)
                begin
                    held_values.delete(pos);
                end
                else
                begin
                    view.status = ST_NOTFOUND;
                end
            end
            CMD_POP_TOP:
            begin
                if (held_values.size() == 0)
                begin
                    view.status = ST_EMPTY;
                end
                else
                begin
                    void'(held_values.pop_front());
                end
            end
            CMD_CLEAR:
            begin
                held_values.delete();
            end
            default:
            begin
            end
        endcase
        view.count = CNT_W'(held_values.size());
        view.empty = (held_values.size() == 0);
        if (held_values.size() == 0)
        begin
            view.top    = '0;
            view.bottom = '0;
        end
        else
        begin
            view.top    = held_values[0];
            view.bottom = held_values[held_values.size() - 1];
        end
        return view;
    endfunction

    // Mostly small values and held values, so duplicates and hits are common.
    function automatic logic signed [VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2)
        begin
            return $urandom;
        end
        if (r == 2)
        begin
            case ($urandom_range(0, 3))
                0: return VAL_MAX;
                1: return VAL_MIN;
                2: return '0;
                default: return '1;
            endcase
        end
        if (r < 6 && held_values.size() != 0)
        begin
            return held_values[$urandom_range(0, held_values.size() - 1)];
        end
        return VAL_W'($urandom_range(0, 23)) - 12;
    endfunction

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timeout", $time);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (idle_on && $urandom_range(0, 4) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 2);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // The model is updated when a word is accepted; results are checked in order.
    always @(posedge clk)
    begin : result_monitor
        deque_view_t seen;
        deque_view_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                expected_views.push_back(apply_command(command, value));
            end
            if (out_valid && !out_stall)
            begin
                seen = '{status, top_value, bottom_value, entry_count, is_empty};
                if (expected_views.size() == 0)
                begin
                    error_count++;
                    $display("%0t: expected no result, actual status %0d count %0d",
                             $time, seen.status, seen.count);
                end
                else
                begin
                    want = expected_views.pop_front();
                    if (seen !== want)
                    begin
                        error_count++;
                        $display("%0t: expected st %0d top %0d bot %0d cnt %0d emp %0d",
                                 $time, want.status, want.top, want.bottom,
                                 want.count, want.empty);
                        $display("%0t: actual   st %0d top %0d bot %0d cnt %0d emp %0d",
                                 $time, seen.status, seen.top, seen.bottom,
                                 seen.count, seen.empty);
                    end
                end
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic signed [VAL_W-1:0] val);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        in_valid = 1'b1;
        command  = cmd;
        value    = val;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic test_directed_edges();
        send_word(CMD_POP_TOP, '0);
        send_word(CMD_REMOVE, 32'sd7);
        send_word(CMD_CLEAR, '1);
        for (int c = CMD_SPARE_LO; c <= CMD_SPARE_HI; c++)
        begin
            send_word(CMD_W'(c), -32'sd1);
        end
        send_word(CMD_PUSH_TOP, VAL_MAX);
        send_word(CMD_PUSH_BOTTOM, VAL_MIN);
        send_word(CMD_PUSH_TOP, '0);
        send_word(CMD_PUSH_TOP, VAL_MAX);
        send_word(CMD_PUSH_BOTTOM, VAL_MIN);
        // Middle, then bottom, then the sole value.
        send_word(CMD_REMOVE, VAL_MAX);
        send_word(CMD_REMOVE, VAL_MIN);
        send_word(CMD_REMOVE, '0);
        send_word(CMD_PUSH_BOTTOM, -32'sd1);
        send_word(CMD_PUSH_BOTTOM, 32'sd1);
        send_word(CMD_PUSH_TOP, 32'sd3);
        send_word(CMD_REMOVE, 32'sd3);
        send_word(CMD_POP_TOP, VAL_MAX);
        send_word(CMD_POP_TOP, VAL_MIN);
        send_word(CMD_PUSH_TOP, 32'sd5);
        send_word(CMD_SPARE_LO, 32'sd5);
        send_word(CMD_CLEAR, '0);
        send_word(CMD_CLEAR, '0);
    endtask

    task automatic test_full_store();
        send_word(CMD_CLEAR, '0);
        while (held_values.size() < DEPTH)
        begin
            send_word($urandom_range(0, 1) ? CMD_PUSH_TOP : CMD_PUSH_BOTTOM, $urandom);
        end
        send_word(CMD_PUSH_TOP, $urandom);
        send_word(CMD_PUSH_BOTTOM, $urandom);
        // The duplicate check wins over the full check.
        send_word(CMD_PUSH_TOP, held_values[DEPTH / 2]);
        send_word(CMD_PUSH_BOTTOM, held_values[0]);
        send_word(CMD_REMOVE, held_values[DEPTH - 1]);
        send_word(CMD_REMOVE, held_values[0]);
        send_word(CMD_PUSH_BOTTOM, VAL_MIN);
        send_word(CMD_POP_TOP, '0);
        send_word(CMD_CLEAR, '0);
    endtask

    task automatic test_random_mix(input int words);
        int r;
        for (int n = 0; n < words; n++)
        begin
            if (n % 64 == 0)
            begin
                idle_on = ($urandom_range(0, 3) != 0);
            end
            r = $urandom_range(0, 99);
            if (r < 27)
            begin
                send_word(CMD_PUSH_TOP, pick_value());
            end
            else if (r < 54)
            begin
                send_word(CMD_PUSH_BOTTOM, pick_value());
            end
            else if (r < 78)
            begin
                if (held_values.size() != 0 && $urandom_range(0, 9) < 7)
                begin
                    send_word(CMD_REMOVE,
                              held_values[$urandom_range(0, held_values.size() - 1)]);
                end
                else
                begin
                    send_word(CMD_REMOVE, pick_value());
                end
            end
            else if (r < 90)
            begin
                send_word(CMD_POP_TOP, $urandom);
            end
            else if (r < 94)
            begin
                send_word(CMD_CLEAR, $urandom);
            end
            else
            begin
                send_word(CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)), pick_value());
            end
        end
    endtask

    // Each round fills the deque past full, then drains it by removes and pops.
    task automatic test_fill_drain(input int rounds);
        int r;
        for (int n = 0; n < rounds; n++)
        begin
            send_word(CMD_CLEAR, $urandom);
            while (held_values.size() < DEPTH)
            begin
                send_word($urandom_range(0, 1) ? CMD_PUSH_TOP : CMD_PUSH_BOTTOM,
                          ($urandom_range(0, 5) == 0) ? pick_value() : $urandom);
            end
            repeat ($urandom_range(1, 3))
            begin
                send_word($urandom_range(0, 1) ? CMD_PUSH_TOP : CMD_PUSH_BOTTOM,
                          pick_value());
            end
            while (held_values.size() != 0)
            begin
                r = $urandom_range(0, 9);
                if (r < 6)
                begin
                    send_word(CMD_REMOVE,
                              held_values[$urandom_range(0, held_values.size() - 1)]);
                end
                else if (r < 9)
                begin
                    send_word(CMD_POP_TOP, $urandom);
                end
                else
                begin
                    send_word(CMD_REMOVE, $urandom);
                end
            end
            send_word(CMD_POP_TOP, $urandom);
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n   = 1'b1;
        idle_on = 1'b1;
        test_directed_edges();
        test_full_store();
        test_random_mix(850);
        idle_on = 1'b1;
        test_fill_drain(13);
        idle_on = 1'b0;
        test_fill_drain(5);
        in_valid = 1'b0;
        while (expected_views.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/uvd_pkg.sv
hw/rtl/uvd_datapath.sv
hw/rtl/uvd_controller.sv
hw/rtl/unique_value_deque_top.sv
tb/unique_value_deque_top_test.sv
